FILE: rtl/two_stage_channel_averager_core_defines.svh
// ----------------------------------------------------------------------------
// Two-stage channel averager: assertion macros
// Shared assertion macros for the checker of the averager core. They expect
// a clock named clk and an active-low reset named rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef TWO_STAGE_CHANNEL_AVERAGER_CORE_DEFINES_SVH
`define TWO_STAGE_CHANNEL_AVERAGER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TSCA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("two_stage_channel_averager_core: check failed");

// Next-cycle implication, disabled during reset.
`define TSCA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("two_stage_channel_averager_core: check failed");

`endif

FILE: rtl/tsca_pkg.sv
// ----------------------------------------------------------------------------
// Two-stage channel averager package
// Field widths, item and control types, codes and reset values shared by
// the averager core, its divider, its register block and its checker.
// ----------------------------------------------------------------------------
package tsca_pkg;

    localparam int KIND_W    = 2;
    localparam int CH_W      = 2;
    localparam int RAW_W     = 12;
    localparam int MV_W      = 16;
    localparam int CFG_W     = 8;
    localparam int CNT_W     = 8;
    localparam int RAW_SUM_W = 20;
    localparam int MV_SUM_W  = 24;
    localparam int CFG_IDX_W = 1;

    // The divider walks the widest dividend one bit per step.
    localparam int DIV_STEPS = MV_SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STAGE1_LEN          = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGES_PER_PERIOD = 1'd1;

    localparam logic [CFG_W-1:0] STAGE1_LEN_RST          = 8'd60;
    localparam logic [CFG_W-1:0] AVERAGES_PER_PERIOD_RST = 8'd10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CH_W-1:0]   channel;
        logic              running;
        logic [RAW_W-1:0]  adc_raw;
        logic [MV_W-1:0]   adc_mv;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]  out_channel;
        logic             first_sample;
        logic             minute_valid;
        logic [RAW_W-1:0] minute_raw;
        logic [MV_W-1:0]  minute_mv;
        logic             period_valid;
        logic [RAW_W-1:0] period_raw;
        logic [MV_W-1:0]  period_mv;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] stage1_len;
        logic [CFG_W-1:0] averages_per_period;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [CNT_W-1:0]     divisor;
        logic [RAW_SUM_W-1:0] dividend_raw;
        logic [MV_SUM_W-1:0]  dividend_mv;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [RAW_SUM_W-1:0] quot_raw;
        logic [MV_SUM_W-1:0]  quot_mv;
    } div_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MINUTE,
        ST_PERIOD,
        ST_OUT
    } seq_state_t;

endpackage

FILE: rtl/tsca_cfg_regs.sv
// ----------------------------------------------------------------------------
// Averager configuration registers
// Holds the first-stage and second-stage lengths, written by index.
// ----------------------------------------------------------------------------
module tsca_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [tsca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsca_pkg::CFG_W-1:0]     cfg_data,
    output tsca_pkg::cfg_t                 cfg
);
    import tsca_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_STAGE1_LEN:          cfg_next.stage1_len          = cfg_data;
                REG_AVERAGES_PER_PERIOD: cfg_next.averages_per_period = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stage1_len          <= STAGE1_LEN_RST;
            cfg_reg.averages_per_period <= AVERAGES_PER_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/tsca_divider.sv
// ----------------------------------------------------------------------------
// Averager shared divider
// Restoring divider, one quotient bit per cycle, that divides a raw-code sum
// and a millivolt sum by the same count side by side.
// ----------------------------------------------------------------------------
module tsca_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  tsca_pkg::div_req_t req,
    output tsca_pkg::div_rsp_t rsp
);
    import tsca_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;

    logic [CNT_W-1:0]    divisor_reg, divisor_next;
    logic [CNT_W-1:0]    rem_raw_reg, rem_raw_next;
    logic [CNT_W-1:0]    rem_mv_reg, rem_mv_next;
    logic [MV_SUM_W-1:0] q_raw_reg, q_raw_next;
    logic [MV_SUM_W-1:0] q_mv_reg, q_mv_next;

    logic [CNT_W:0] trial_raw, trial_mv;
    logic [CNT_W:0] diff_raw, diff_mv;
    logic           fits_raw, fits_mv;

    // The quotient registers start out holding the dividend; each step
    // shifts one dividend bit into the remainder and one quotient bit in.
    always_comb
    begin
        trial_raw = {rem_raw_reg, q_raw_reg[MV_SUM_W-1]};
        trial_mv  = {rem_mv_reg, q_mv_reg[MV_SUM_W-1]};
        fits_raw  = trial_raw >= {1'b0, divisor_reg};
        fits_mv   = trial_mv >= {1'b0, divisor_reg};
        diff_raw  = trial_raw - {1'b0, divisor_reg};
        diff_mv   = trial_mv - {1'b0, divisor_reg};
    end

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        divisor_next = divisor_reg;
        rem_raw_next = rem_raw_reg;
        rem_mv_next  = rem_mv_reg;
        q_raw_next   = q_raw_reg;
        q_mv_next    = q_mv_reg;

        if (req.start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            divisor_next = req.divisor;
            rem_raw_next = '0;
            rem_mv_next  = '0;
            q_raw_next   = MV_SUM_W'(req.dividend_raw);
            q_mv_next    = req.dividend_mv;
        end
        else if (busy_reg)
        begin
            rem_raw_next = fits_raw ? diff_raw[CNT_W-1:0] : trial_raw[CNT_W-1:0];
            rem_mv_next  = fits_mv ? diff_mv[CNT_W-1:0] : trial_mv[CNT_W-1:0];
            q_raw_next   = {q_raw_reg[MV_SUM_W-2:0], fits_raw};
            q_mv_next    = {q_mv_reg[MV_SUM_W-2:0], fits_mv};
            step_next    = step_reg + 1'b1;
            if (step_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        rem_raw_reg <= rem_raw_next;
        rem_mv_reg  <= rem_mv_next;
        q_raw_reg   <= q_raw_next;
        q_mv_reg    <= q_mv_next;
    end

    // Averages never exceed the largest input, so the low bits carry it all.
    assign rsp.done     = done_reg;
    assign rsp.quot_raw = q_raw_reg[RAW_SUM_W-1:0];
    assign rsp.quot_mv  = q_mv_reg;

endmodule

FILE: rtl/two_stage_channel_averager_core.sv
// ----------------------------------------------------------------------------
// Two-stage channel averager core
// Per-channel block averages of raw ADC codes and millivolts, cascaded into
// a period average, with one serial divider shared by both stages.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+-------------------------------
//   input   | in_valid / in_ready   | in_item  (tsca_pkg::in_item_t)
//   output  | out_valid / out_ready | out_item (tsca_pkg::out_item_t)
//   config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Every item gives exactly one result item. Control items, ignored items and
// samples that complete no average go straight to the output state; each
// average computed adds a pass through the shared divider to the item's work.
// Reset clears all channel sums and counts; the configuration port is always
// ready. A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module two_stage_channel_averager_core #(
    parameter int CHANNELS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  tsca_pkg::in_item_t             in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output tsca_pkg::out_item_t            out_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tsca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsca_pkg::CFG_W-1:0]     cfg_data
);
    import tsca_pkg::*;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    seq_state_t state_reg, state_next;

    logic [CH_IDX_W-1:0] ch_idx_reg, ch_idx_next;
    out_item_t           res_reg, res_next;
    out_item_t           out_item_reg, out_item_next;
    logic                out_valid_reg, out_valid_next;

    logic [RAW_SUM_W-1:0] s1_raw_reg [CHANNELS];
    logic [RAW_SUM_W-1:0] s1_raw_next [CHANNELS];
    logic [MV_SUM_W-1:0]  s1_mv_reg [CHANNELS];
    logic [MV_SUM_W-1:0]  s1_mv_next [CHANNELS];
    logic [CNT_W-1:0]     s1_cnt_reg [CHANNELS];
    logic [CNT_W-1:0]     s1_cnt_next [CHANNELS];
    logic [RAW_SUM_W-1:0] s2_raw_reg [CHANNELS];
    logic [RAW_SUM_W-1:0] s2_raw_next [CHANNELS];
    logic [MV_SUM_W-1:0]  s2_mv_reg [CHANNELS];
    logic [MV_SUM_W-1:0]  s2_mv_next [CHANNELS];
    logic [CNT_W-1:0]     s2_cnt_reg [CHANNELS];
    logic [CNT_W-1:0]     s2_cnt_next [CHANNELS];
    logic                 first_reg [CHANNELS];
    logic                 first_next [CHANNELS];

    logic                 in_fire;
    logic                 out_load;
    logic [CH_IDX_W-1:0]  in_idx;
    logic                 in_ch_ok;
    logic [RAW_SUM_W-1:0] acc1_raw;
    logic [MV_SUM_W-1:0]  acc1_mv;
    logic [CNT_W-1:0]     acc1_cnt;
    logic [RAW_SUM_W-1:0] acc2_raw;
    logic [MV_SUM_W-1:0]  acc2_mv;
    logic [CNT_W-1:0]     acc2_cnt;

    tsca_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tsca_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign in_idx    = CH_IDX_W'(in_item.channel);
    assign in_ch_ok  = int'(in_item.channel) < CHANNELS;

    // First stage works on the arriving item, second stage on the latched
    // channel once the minute average is out of the divider.
    always_comb
    begin
        acc1_raw = s1_raw_reg[in_idx] + RAW_SUM_W'(in_item.adc_raw);
        acc1_mv  = s1_mv_reg[in_idx] + MV_SUM_W'(in_item.adc_mv);
        acc1_cnt = s1_cnt_reg[in_idx] + 1'b1;
        acc2_raw = s2_raw_reg[ch_idx_reg] + div_rsp.quot_raw;
        acc2_mv  = s2_mv_reg[ch_idx_reg] + div_rsp.quot_mv;
        acc2_cnt = s2_cnt_reg[ch_idx_reg] + 1'b1;
    end

    always_comb
    begin
        state_next  = state_reg;
        ch_idx_next = ch_idx_reg;
        res_next    = res_reg;
        out_load    = 1'b0;
        s1_raw_next = s1_raw_reg;
        s1_mv_next  = s1_mv_reg;
        s1_cnt_next = s1_cnt_reg;
        s2_raw_next = s2_raw_reg;
        s2_mv_next  = s2_mv_reg;
        s2_cnt_next = s2_cnt_reg;
        first_next  = first_reg;

        div_req.start        = 1'b0;
        div_req.divisor      = acc1_cnt;
        div_req.dividend_raw = acc1_raw;
        div_req.dividend_mv  = acc1_mv;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ch_idx_next          = in_idx;
                    res_next             = '0;
                    res_next.out_channel = in_item.channel;
                    state_next           = ST_OUT;
                    if (in_ch_ok)
                    begin
                        if (in_item.kind == KIND_START || in_item.kind == KIND_STOP)
                        begin
                            s1_raw_next[in_idx] = '0;
                            s1_mv_next[in_idx]  = '0;
                            s1_cnt_next[in_idx] = '0;
                            s2_raw_next[in_idx] = '0;
                            s2_mv_next[in_idx]  = '0;
                            s2_cnt_next[in_idx] = '0;
                            first_next[in_idx]  = (in_item.kind == KIND_START);
                        end
                        else if (in_item.kind == KIND_SAMPLE && in_item.running)
                        begin
                            res_next.first_sample = first_reg[in_idx];
                            first_next[in_idx]    = 1'b0;
                            // A length of zero completes on every sample, as the
                            // compare below already does.
                            if (acc1_cnt >= cfg.stage1_len)
                            begin
                                div_req.start       = 1'b1;
                                s1_raw_next[in_idx] = '0;
                                s1_mv_next[in_idx]  = '0;
                                s1_cnt_next[in_idx] = '0;
                                state_next          = ST_MINUTE;
                            end
                            else
                            begin
                                s1_raw_next[in_idx] = acc1_raw;
                                s1_mv_next[in_idx]  = acc1_mv;
                                s1_cnt_next[in_idx] = acc1_cnt;
                            end
                        end
                    end
                end
            end

            ST_MINUTE:
            begin
                div_req.divisor      = acc2_cnt;
                div_req.dividend_raw = acc2_raw;
                div_req.dividend_mv  = acc2_mv;
                if (div_rsp.done)
                begin
                    res_next.minute_valid = 1'b1;
                    res_next.minute_raw   = div_rsp.quot_raw[RAW_W-1:0];
                    res_next.minute_mv    = div_rsp.quot_mv[MV_W-1:0];
                    if (acc2_cnt >= cfg.averages_per_period)
                    begin
                        div_req.start           = 1'b1;
                        s2_raw_next[ch_idx_reg] = '0;
                        s2_mv_next[ch_idx_reg]  = '0;
                        s2_cnt_next[ch_idx_reg] = '0;
                        state_next              = ST_PERIOD;
                    end
                    else
                    begin
                        s2_raw_next[ch_idx_reg] = acc2_raw;
                        s2_mv_next[ch_idx_reg]  = acc2_mv;
                        s2_cnt_next[ch_idx_reg] = acc2_cnt;
                        state_next              = ST_OUT;
                    end
                end
            end

            ST_PERIOD:
            begin
                if (div_rsp.done)
                begin
                    res_next.period_valid = 1'b1;
                    res_next.period_raw   = div_rsp.quot_raw[RAW_W-1:0];
                    res_next.period_mv    = div_rsp.quot_mv[MV_W-1:0];
                    state_next            = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_item_next  = res_reg;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                s1_raw_reg[c] <= '0;
                s1_mv_reg[c]  <= '0;
                s1_cnt_reg[c] <= '0;
                s2_raw_reg[c] <= '0;
                s2_mv_reg[c]  <= '0;
                s2_cnt_reg[c] <= '0;
                first_reg[c]  <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            s1_raw_reg    <= s1_raw_next;
            s1_mv_reg     <= s1_mv_next;
            s1_cnt_reg    <= s1_cnt_next;
            s2_raw_reg    <= s2_raw_next;
            s2_mv_reg     <= s2_mv_next;
            s2_cnt_reg    <= s2_cnt_next;
            first_reg     <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_idx_reg   <= ch_idx_next;
        res_reg      <= res_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: rtl/tsca_checker.sv
// ----------------------------------------------------------------------------
// Two-stage channel averager checker
// Port-level checks on the averager core, attached to it by a bind.
// ----------------------------------------------------------------------------
`include "two_stage_channel_averager_core_defines.svh"

module tsca_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input tsca_pkg::out_item_t out_item
);
    import tsca_pkg::*;

    logic avg_fields_zero;

    assign avg_fields_zero = out_item.minute_raw == '0 && out_item.minute_mv == '0
                             && !out_item.period_valid && out_item.period_raw == '0
                             && out_item.period_mv == '0;

    // The core works on one item at a time.
    `TSCA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // A new result is only presented after the core stopped taking items.
    `TSCA_ASSERT_IMP(a_result_after_work, $rose(out_valid), $past(!in_ready))

    `TSCA_ASSERT_NXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_item))

    // When no minute average completed, the fields of both averages read as zero,
    // and a period average never completes without a minute average.
    `TSCA_ASSERT_IMP(a_idle_fields_zero, out_valid && !out_item.minute_valid, avg_fields_zero)

endmodule

bind two_stage_channel_averager_core tsca_checker u_tsca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-stage channel averager core testbench
// Sends sample, start, stop and reserved items through the input channel
// with random gaps and output stalls. Each result is checked field by field
// against a per-channel software copy of both averaging stages. Covers
// directed corner cases, extreme and degenerate lengths, lengths lowered in
// the middle of a block, and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb;

    import tsca_pkg::*;

    localparam int CHANNELS     = 4;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 4;
    localparam int ITEM_LATENCY = 60;

    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Software copy of the averaging state.
    logic [RAW_SUM_W-1:0] minute_raw_acc [CHANNELS];
    logic [MV_SUM_W-1:0]  minute_mv_acc  [CHANNELS];
    logic [CNT_W-1:0]     minute_fill    [CHANNELS];
    logic [RAW_SUM_W-1:0] period_raw_acc [CHANNELS];
    logic [MV_SUM_W-1:0]  period_mv_acc  [CHANNELS];
    logic [CNT_W-1:0]     period_fill    [CHANNELS];
    logic                 first_armed    [CHANNELS];
    logic [CFG_W-1:0]     minute_len;
    logic [CFG_W-1:0]     period_len;

    out_item_t awaited_reports [$];
    int        mismatches;
    int        cycle_count;
    bit        tx_burst;
    bit        rx_burst;
    logic      hold_request;
    logic      hold_active;

    two_stage_channel_averager_core #(
        .CHANNELS (CHANNELS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic void clear_channel_sums(input int c);
        minute_raw_acc[c] = '0;
        minute_mv_acc[c]  = '0;
        minute_fill[c]    = '0;
        period_raw_acc[c] = '0;
        period_mv_acc[c]  = '0;
        period_fill[c]    = '0;
    endfunction

    // Advances the channel state by one item and returns the report it gives.
    function automatic out_item_t compute_channel_report(input in_item_t item);
        out_item_t            rep;
        int                   c;
        logic [RAW_SUM_W-1:0] avg_raw;
        logic [MV_SUM_W-1:0]  avg_mv;
        rep = '0;
        rep.out_channel = item.channel;
        c = int'(item.channel);
        if (c >= CHANNELS)
            return rep;
        if (item.kind == KIND_START)
        begin
            clear_channel_sums(c);
            first_armed[c] = 1'b1;
        end
        else if (item.kind == KIND_STOP)
        begin
            clear_channel_sums(c);
            first_armed[c] = 1'b0;
        end
        else if (item.kind == KIND_SAMPLE && item.running)
        begin
            minute_raw_acc[c] += RAW_SUM_W'(item.adc_raw);
            minute_mv_acc[c]  += MV_SUM_W'(item.adc_mv);
            minute_fill[c]    += CNT_W'(1);
            if (first_armed[c])
            begin
                first_armed[c] = 1'b0;
                rep.first_sample = 1'b1;
            end
            // A length of zero behaves like one, and a lowered length closes
            // the block at once, dividing by the count actually held.
            if (minute_fill[c] >= minute_len)
            begin
                avg_raw = minute_raw_acc[c] / minute_fill[c];
                avg_mv  = minute_mv_acc[c] / minute_fill[c];
                minute_raw_acc[c] = '0;
                minute_mv_acc[c]  = '0;
                minute_fill[c]    = '0;
                rep.minute_valid = 1'b1;
                rep.minute_raw   = avg_raw[RAW_W-1:0];
                rep.minute_mv    = avg_mv[MV_W-1:0];
                period_raw_acc[c] += avg_raw;
                period_mv_acc[c]  += avg_mv;
                period_fill[c]    += CNT_W'(1);
                if (period_fill[c] >= period_len)
                begin
                    avg_raw = period_raw_acc[c] / period_fill[c];
                    avg_mv  = period_mv_acc[c] / period_fill[c];
                    period_raw_acc[c] = '0;
                    period_mv_acc[c]  = '0;
                    period_fill[c]    = '0;
                    rep.period_valid = 1'b1;
                    rep.period_raw   = avg_raw[RAW_W-1:0];
                    rep.period_mv    = avg_mv[MV_W-1:0];
                end
            end
        end
        return rep;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_report(input out_item_t got);
        out_item_t want;
        if (awaited_reports.size() == 0)
        begin
            $display("%0t: result item with none expected, expected nothing, got %p",
                     $time, got);
            mismatches++;
            return;
        end
        want = awaited_reports.pop_front();
        check_field("out_channel",  want.out_channel,  got.out_channel);
        check_field("first_sample", want.first_sample, got.first_sample);
        check_field("minute_valid", want.minute_valid, got.minute_valid);
        check_field("minute_raw",   want.minute_raw,   got.minute_raw);
        check_field("minute_mv",    want.minute_mv,    got.minute_mv);
        check_field("period_valid", want.period_valid, got.period_valid);
        check_field("period_raw",   want.period_raw,   got.period_raw);
        check_field("period_mv",    want.period_mv,    got.period_mv);
    endfunction

    // Result side: random stalls, plus the long hold-off when one is active.
    initial
    begin : result_sink
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = rx_burst ? 0 : $urandom_range(11, 0);
            if (stall > 0 || hold_active)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_active)
                    @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            check_report(out_item);
        end
    end

    initial
    begin : hold_timer
        hold_active <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request <= 1'b0;
                hold_active  <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active  <= 1'b0;
            end
        end
    end

    function automatic in_item_t make_item(input logic [KIND_W-1:0] kind, input int ch,
                                           input logic run, input int raw, input int mv);
        in_item_t item;
        item.kind    = kind;
        item.channel = CH_W'(ch);
        item.running = run;
        item.adc_raw = RAW_W'(raw);
        item.adc_mv  = MV_W'(mv);
        return item;
    endfunction

    task automatic send_item(input in_item_t item);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(11, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        awaited_reports.push_back(compute_channel_report(item));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_lengths(input logic [CFG_W-1:0] per_minute,
                               input logic [CFG_W-1:0] per_period);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= REG_STAGE1_LEN;
        cfg_data  <= per_minute;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        minute_len = per_minute;
        cfg_index <= REG_AVERAGES_PER_PERIOD;
        cfg_data  <= per_period;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        period_len = per_period;
        cfg_valid <= 1'b0;
    endtask

    // Mostly running samples with random content; ctrl_pct percent of the
    // items are starts, stops, paused samples or reserved kinds.
    task automatic send_random_run(input int count, input int ch_lo, input int ch_hi,
                                   input int ctrl_pct);
        in_item_t item;
        int       roll;
        for (int i = 0; i < count; i++)
        begin
            item.channel = CH_W'($urandom_range(ch_hi, ch_lo));
            roll = $urandom_range(9, 0);
            item.adc_raw = (roll == 0) ? 12'd0 : (roll == 1) ? 12'hFFF
                                               : 12'($urandom_range(4095, 0));
            roll = $urandom_range(9, 0);
            item.adc_mv = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF
                                              : 16'($urandom_range(65535, 0));
            item.kind    = KIND_SAMPLE;
            item.running = 1'b1;
            if ($urandom_range(99, 0) < ctrl_pct)
            begin
                item.running = 1'($urandom_range(1, 0));
                case ($urandom_range(4, 0))
                    0, 1: item.kind = KIND_START;
                    2:    item.kind = KIND_STOP;
                    3:    item.running = 1'b0;
                    default: item.kind = KIND_RESERVED;
                endcase
            end
            send_item(item);
        end
    endtask

    task automatic test_control_items();
        send_item(make_item(KIND_START,    0, 1'b0, 123, 4567));
        send_item(make_item(KIND_SAMPLE,   0, 1'b1, 4095, 65535));
        send_item(make_item(KIND_SAMPLE,   0, 1'b1, 0, 0));
        send_item(make_item(KIND_SAMPLE,   0, 1'b0, 4095, 65535));
        send_item(make_item(KIND_RESERVED, 0, 1'b1, 4095, 65535));
        send_item(make_item(KIND_STOP,     0, 1'b1, 4095, 65535));
        send_item(make_item(KIND_SAMPLE,   3, 1'b1, 2048, 32768));
    endtask

    task automatic test_short_blocks();
        set_lengths(8'd2, 8'd2);
        send_item(make_item(KIND_START,  1, 1'b1, 0, 0));
        send_item(make_item(KIND_SAMPLE, 1, 1'b1, 4095, 65535));
        send_item(make_item(KIND_SAMPLE, 1, 1'b1, 4095, 65535));
        send_item(make_item(KIND_SAMPLE, 1, 1'b1, 4094, 65534));
        send_item(make_item(KIND_SAMPLE, 1, 1'b1, 1, 1));
        send_item(make_item(KIND_STOP,   1, 1'b0, 0, 0));
        send_item(make_item(KIND_SAMPLE, 1, 1'b1, 7, 9));
    endtask

    task automatic test_degenerate_lengths();
        set_lengths(8'd0, 8'd0);
        send_item(make_item(KIND_SAMPLE, 2, 1'b1, 4095, 65535));
        send_item(make_item(KIND_SAMPLE, 2, 1'b1, 1000, 3333));
        set_lengths(8'd5, 8'd3);
        send_item(make_item(KIND_SAMPLE, 0, 1'b1, 4095, 65535));
        send_item(make_item(KIND_SAMPLE, 0, 1'b1, 17, 300));
        send_item(make_item(KIND_SAMPLE, 0, 1'b1, 2000, 40000));
        // The block is three deep when its length drops below that.
        set_lengths(8'd2, 8'd3);
        send_item(make_item(KIND_SAMPLE, 0, 1'b1, 5, 6));
    endtask

    task automatic test_length_extremes();
        set_lengths(8'd255, 8'd1);
        send_random_run(260, 2, 2, 0);
        set_lengths(8'd1, 8'd255);
        send_random_run(260, 3, 3, 0);
    endtask

    task automatic test_random_traffic();
        set_lengths(8'd3, 8'd2);
        send_random_run(200, 0, CHANNELS - 1, 20);
        set_lengths(8'd0, 8'd0);
        send_random_run(80, 0, CHANNELS - 1, 20);
        for (int round = 0; round < 3; round++)
        begin
            tx_burst = (round == 1);
            rx_burst = (round == 1);
            set_lengths(CFG_W'($urandom_range(6, 1)), CFG_W'($urandom_range(4, 1)));
            send_random_run(60, 0, CHANNELS - 1, 20);
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    task automatic test_output_backpressure();
        set_lengths(8'd2, 8'd2);
        hold_request <= 1'b1;
        tx_burst = 1'b1;
        send_random_run(40, 0, CHANNELS - 1, 10);
        tx_burst = 1'b0;
    endtask

    initial
    begin : test_sequence
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_item      <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        hold_request <= 1'b0;
        mismatches = 0;
        tx_burst   = 1'b0;
        rx_burst   = 1'b0;
        minute_len = STAGE1_LEN_RST;
        period_len = AVERAGES_PER_PERIOD_RST;
        for (int c = 0; c < CHANNELS; c++)
        begin
            clear_channel_sums(c);
            first_armed[c] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_control_items();
        test_short_blocks();
        test_degenerate_lengths();
        test_length_extremes();
        test_random_traffic();
        test_output_backpressure();

        wait_drained();
        repeat (ITEM_LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
